// ----- rtl/tcx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tcx_pkg;
	localparam int CITY_W       = 10;
	localparam int CITY_SPACE   = 1024;
	localparam int MAX_CITIES_D = 1024;
	localparam int SEG_START    = 3;
	localparam int SEG_MIN_N    = 6;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_BUILD = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
endpackage
`default_nettype wire

// ----- rtl/tcx_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tcx_ram #(
	parameter int W = 10,
	parameter int D = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/tour_crossover_with_repair.sv -----
// Channel  | Port group          | Word layout (lowest bit first)
// input    | s_tvalid/s_tready   | tdata: position, parent_a_city, parent_b_city; tuser: operation
// output   | m_tvalid/m_tready   | tdata: child_a_city, child_b_city; tuser: built
// config   | cfg_wr_en           | cfg_wr_data: city_count
//
// Load and no-op words go straight to the output register; a read word passes the read-wait
// state first. A build runs a clearing pass over both presence memories, then a read and a
// write per segment position, a placement pass that reads, probes and writes each other inner
// position and skips segment positions, and for each child a fill pass that checks each inner
// position and scans for free cities at holes, all set by the one-read-port memories.
// Reset (arst_n low) returns the controller to idle and city_count to 8; tour memories are
// not cleared. Input is not taken while the output register holds an untaken word.
`timescale 1ns / 1ps
`default_nettype none
module tour_crossover_with_repair #(
	parameter int MAX_CITIES = tcx_pkg::MAX_CITIES_D
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // position, parent_a_city, parent_b_city, zero pad
	input  wire logic [1:0]  s_tuser,   // operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // child_a_city, child_b_city, zero pad
	output logic      [0:0]  m_tuser,   // built
	input  wire logic        cfg_wr_en,
	input  wire logic [9:0]  cfg_wr_data
);
	localparam int AW = $clog2(MAX_CITIES);
	localparam int CW = tcx_pkg::CITY_W;
	localparam int SW = $clog2(tcx_pkg::CITY_SPACE);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RDW   = 4'd1;
	localparam logic [3:0] ST_CLR   = 4'd2;
	localparam logic [3:0] ST_SEGR  = 4'd3;
	localparam logic [3:0] ST_SEGW  = 4'd4;
	localparam logic [3:0] ST_PLR   = 4'd5;
	localparam logic [3:0] ST_PLP   = 4'd6;
	localparam logic [3:0] ST_PLW   = 4'd7;
	localparam logic [3:0] ST_FLR   = 4'd8;
	localparam logic [3:0] ST_FLC   = 4'd9;
	localparam logic [3:0] ST_SCR   = 4'd10;
	localparam logic [3:0] ST_SCC   = 4'd11;
	localparam logic [3:0] ST_DONE  = 4'd12;

	logic [3:0]    state_q;
	logic [CW-1:0] city_count_q, nb_q, lo_q, hi_q, j_q, pa_q, pb_q;
	logic [SW-1:0] clr_q;
	logic [SW:0]   next_q;
	logic          side_q, built_q, rd_ok_q, out_valid_q;
	logic [2*CW-1:0] out_data_q;

	logic [CW-1:0] in_pos, in_ca, in_cb, n_eff;
	logic          accept, in_seg, out_load;

	// memory ports
	logic            par_we;
	logic [AW-1:0]   par_waddr, par_raddr;
	logic [2*CW-1:0] par_wdata, par_rdata;
	logic            cha_we, chb_we;
	logic [AW-1:0]   cha_waddr, chb_waddr, ch_raddr;
	logic [CW-1:0]   cha_wdata, chb_wdata, cha_rdata, chb_rdata;
	logic            hol_we;
	logic [1:0]      hol_wdata, hol_rdata;
	logic            pra_we, prb_we;
	logic [SW-1:0]   pra_waddr, prb_waddr, pra_raddr, prb_raddr;
	logic [0:0]      pra_wdata, prb_wdata, pra_rdata, prb_rdata;

	assign in_pos = s_tdata[CW-1:0];
	assign in_ca  = s_tdata[2*CW-1:CW];
	assign in_cb  = s_tdata[3*CW-1:2*CW];
	assign n_eff  = (32'(city_count_q) > MAX_CITIES - 1) ? CW'(MAX_CITIES - 1) : city_count_q;
	assign in_seg = (j_q >= lo_q) && (j_q <= hi_q);

	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_data_q};
	assign m_tuser  = built_q;

	// The output register is loaded by load and no-op words, by a finished read and by the
	// end of a build.
	assign out_load = (accept && (s_tuser != tcx_pkg::OP_READ) &&
		(s_tuser != tcx_pkg::OP_BUILD)) || (state_q == ST_RDW) || (state_q == ST_DONE);

	always_comb begin
		par_we    = 1'b0;
		par_waddr = AW'(in_pos);
		par_wdata = {in_cb, in_ca};
		par_raddr = AW'(j_q);
		cha_we = 1'b0; chb_we = 1'b0;
		cha_waddr = AW'(j_q); chb_waddr = AW'(j_q);
		cha_wdata = '0; chb_wdata = '0;
		ch_raddr  = AW'(in_pos);
		hol_we    = 1'b0;
		hol_wdata = {prb_rdata, pra_rdata};
		pra_we = 1'b0; prb_we = 1'b0;
		pra_waddr = clr_q; prb_waddr = clr_q;
		pra_wdata = 1'b1; prb_wdata = 1'b1;
		pra_raddr = next_q[SW-1:0]; prb_raddr = next_q[SW-1:0];
		case (state_q)
			ST_IDLE: begin
				par_we = accept && (s_tuser == tcx_pkg::OP_LOAD) &&
					(32'(in_pos) < MAX_CITIES);
			end
			ST_CLR: begin
				// City 0 is always present; the home positions are written to zero here.
				pra_we = 1'b1; prb_we = 1'b1;
				pra_wdata = (clr_q == '0); prb_wdata = (clr_q == '0);
				if (clr_q == SW'(0) || clr_q == SW'(1)) begin
					cha_we = 1'b1; chb_we = 1'b1;
					cha_waddr = (clr_q == '0) ? '0 : AW'(nb_q);
					chb_waddr = cha_waddr;
				end
			end
			ST_SEGW: begin
				cha_we = 1'b1; chb_we = 1'b1;
				cha_wdata = par_rdata[CW-1:0]; chb_wdata = par_rdata[2*CW-1:CW];
				pra_we = 1'b1; prb_we = 1'b1;
				pra_waddr = par_rdata[SW-1:0]; prb_waddr = par_rdata[CW+SW-1:CW];
			end
			ST_PLP: begin
				pra_raddr = par_rdata[CW+SW-1:CW];
				prb_raddr = par_rdata[SW-1:0];
			end
			ST_PLW: begin
				cha_we = 1'b1; chb_we = 1'b1;
				cha_wdata = pra_rdata[0] ? '0 : pb_q;
				chb_wdata = prb_rdata[0] ? '0 : pa_q;
				pra_we = !pra_rdata[0]; prb_we = !prb_rdata[0];
				pra_waddr = pb_q[SW-1:0]; prb_waddr = pa_q[SW-1:0];
				hol_we = 1'b1;
			end
			ST_SCR: begin
				if (next_q[SW]) begin
					cha_we = !side_q; chb_we = side_q;
				end
			end
			ST_SCC: begin
				if (side_q ? !prb_rdata[0] : !pra_rdata[0]) begin
					cha_we = !side_q; chb_we = side_q;
					pra_we = !side_q; prb_we = side_q;
					cha_wdata = next_q[CW-1:0]; chb_wdata = next_q[CW-1:0];
					pra_waddr = next_q[SW-1:0]; prb_waddr = next_q[SW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			city_count_q <= 10'd8;
			built_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			pa_q <= '0; pb_q <= '0;
			nb_q <= '0; lo_q <= '0; hi_q <= '0; j_q <= '0;
			clr_q <= '0; next_q <= '0; side_q <= 1'b0; rd_ok_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				city_count_q <= cfg_wr_data;
			end
			if (out_valid_q && m_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (s_tuser)
							tcx_pkg::OP_READ: begin
								rd_ok_q <= (in_pos <= n_eff) && (in_pos <= nb_q);
								state_q <= ST_RDW;
							end
							tcx_pkg::OP_BUILD: begin
								nb_q  <= n_eff;
								lo_q  <= (n_eff >= CW'(tcx_pkg::SEG_MIN_N)) ?
									CW'(tcx_pkg::SEG_START) : '0;
								hi_q  <= (n_eff >= CW'(tcx_pkg::SEG_MIN_N)) ?
									n_eff - CW'(tcx_pkg::SEG_START) : '0;
								clr_q <= '0;
								state_q <= ST_CLR;
							end
							default: begin
								if (s_tuser == tcx_pkg::OP_LOAD) begin
									built_q <= 1'b0;
								end
								out_valid_q <= 1'b1;
								out_data_q  <= '0;
							end
						endcase
					end
				end
				ST_RDW: begin
					out_valid_q <= 1'b1;
					out_data_q  <= rd_ok_q ? {chb_rdata, cha_rdata} : '0;
					state_q     <= ST_IDLE;
				end
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						j_q     <= lo_q;
						state_q <= ST_SEGR;
					end
				end
				ST_SEGR: state_q <= ST_SEGW;
				ST_SEGW: begin
					if (j_q == hi_q) begin
						j_q     <= CW'(1);
						state_q <= ST_PLR;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_SEGR;
					end
				end
				ST_PLR: begin
					if (j_q >= nb_q) begin
						j_q <= CW'(1); side_q <= 1'b0; next_q <= '0;
						state_q <= ST_FLR;
					end else if (in_seg) begin
						j_q <= j_q + 1'b1;
					end else begin
						state_q <= ST_PLP;
					end
				end
				ST_PLP: begin
					pa_q    <= par_rdata[CW-1:0];
					pb_q    <= par_rdata[2*CW-1:CW];
					state_q <= ST_PLW;
				end
				ST_PLW: begin
					j_q     <= j_q + 1'b1;
					state_q <= ST_PLR;
				end
				ST_FLR: begin
					if (j_q >= nb_q) begin
						if (!side_q) begin
							side_q <= 1'b1; j_q <= CW'(1); next_q <= '0;
						end else begin
							state_q <= ST_DONE;
						end
					end else if (in_seg) begin
						j_q <= j_q + 1'b1;
					end else begin
						state_q <= ST_FLC;
					end
				end
				ST_FLC: begin
					if (hol_rdata[side_q]) begin
						state_q <= ST_SCR;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_FLR;
					end
				end
				ST_SCR: begin
					if (next_q[SW]) begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_FLR;
					end else begin
						state_q <= ST_SCC;
					end
				end
				ST_SCC: begin
					if (side_q ? prb_rdata[0] : pra_rdata[0]) begin
						next_q  <= next_q + 1'b1;
						state_q <= ST_SCR;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_FLR;
					end
				end
				ST_DONE: begin
					built_q     <= 1'b1;
					out_valid_q <= 1'b1;
					out_data_q  <= '0;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	tcx_ram #(.W(2*CW), .D(MAX_CITIES)) u_parent (
		.clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
		.raddr(par_raddr), .rdata(par_rdata));
	tcx_ram #(.W(CW), .D(MAX_CITIES)) u_child_a (
		.clk(clk), .we(cha_we), .waddr(cha_waddr), .wdata(cha_wdata),
		.raddr(ch_raddr), .rdata(cha_rdata));
	tcx_ram #(.W(CW), .D(MAX_CITIES)) u_child_b (
		.clk(clk), .we(chb_we), .waddr(chb_waddr), .wdata(chb_wdata),
		.raddr(ch_raddr), .rdata(chb_rdata));
	tcx_ram #(.W(2), .D(MAX_CITIES)) u_hole (
		.clk(clk), .we(hol_we), .waddr(AW'(j_q)), .wdata(hol_wdata),
		.raddr(AW'(j_q)), .rdata(hol_rdata));
	tcx_ram #(.W(1), .D(tcx_pkg::CITY_SPACE)) u_present_a (
		.clk(clk), .we(pra_we), .waddr(pra_waddr), .wdata(pra_wdata),
		.raddr(pra_raddr), .rdata(pra_rdata));
	tcx_ram #(.W(1), .D(tcx_pkg::CITY_SPACE)) u_present_b (
		.clk(clk), .we(prb_we), .waddr(prb_waddr), .wdata(prb_wdata),
		.raddr(prb_raddr), .rdata(prb_rdata));

	a_busy_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !out_valid_q)
		else $error("output word pending while a command is in progress");
	a_next_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_q <= (SW+1)'(tcx_pkg::CITY_SPACE))
		else $error("free-city scan ran past the city space");
	a_done_built: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> (built_q && out_valid_q))
		else $error("build finished without flagging built");
endmodule
`default_nettype wire
